FILE: rtl/adep_pkg.sv
// ----------------------------------------------------------------------------
// adep_pkg
// Shared types and constants for the ASCII timestamp to epoch converter.
// ----------------------------------------------------------------------------
package adep_pkg;

  localparam int unsigned EpochW   = 32;
  localparam int unsigned TextHiW  = 64;
  localparam int unsigned TextLoW  = 48;

  // Register stages inside one conversion lane.
  localparam int unsigned LaneStages = 7;

  typedef struct packed {
    logic [TextHiW-1:0] cur_text_high;
    logic [TextLoW-1:0] cur_text_low;
    logic [TextHiW-1:0] last_text_high;
    logic [TextLoW-1:0] last_text_low;
  } in_item_t;

  typedef struct packed {
    logic signed [EpochW-1:0] cur_epoch;
    logic signed [EpochW-1:0] last_epoch;
    logic signed [EpochW-1:0] epoch_difference;
  } out_item_t;

endpackage

FILE: rtl/adep_lane.sv
// ----------------------------------------------------------------------------
// adep_lane
// Seven-stage pipeline converting one CCYYMMDDhhmmss text to seconds since 1970.
// ----------------------------------------------------------------------------
module adep_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [adep_pkg::TextHiW-1:0] text_high_i,
  input  logic [adep_pkg::TextLoW-1:0] text_low_i,
  output logic [adep_pkg::EpochW-1:0]  epoch_o
);
  import adep_pkg::*;

  localparam logic [14:0] YearMin  = 15'd1970;
  localparam logic [14:0] YearMax  = 15'd9000;
  localparam logic [21:0] QuadDays = 22'd1461;

  function automatic logic [7:0] pair_val(input logic [15:0] cc);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = cc[15:8] - 8'd48;
    lo = cc[7:0] - 8'd48;
    return hi * 8'd10 + lo;
  endfunction

  function automatic logic [8:0] month_start(input logic [7:0] m);
    logic [8:0] r;
    case (m)
      8'd2:    r = 9'd31;
      8'd3:    r = 9'd59;
      8'd4:    r = 9'd90;
      8'd5:    r = 9'd120;
      8'd6:    r = 9'd151;
      8'd7:    r = 9'd181;
      8'd8:    r = 9'd212;
      8'd9:    r = 9'd243;
      8'd10:   r = 9'd273;
      8'd11:   r = 9'd304;
      8'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Stage 1: character pairs.
  logic [7:0] cen_q, yy_q, mon_q, day1_q, hour1_q, min1_q, sec1_q;
  // Stage 2: full year and month offset.
  logic [14:0] year_q;
  logic [8:0]  mstart_q;
  logic        late_mon_q;
  logic [7:0]  day2_q, hour2_q, min2_q, sec2_q;
  // Stage 3: day count parts.
  logic [21:0] quad_days_q;
  logic [11:0] side_days_q;
  logic        ok3_q;
  logic [7:0]  day3_q, hour3_q, min3_q, sec3_q;
  // Stages 4 to 7.
  logic [EpochW-1:0] days_q, hrs_q, mins_q, secs_q;
  logic              ok4_q, ok5_q, ok6_q;
  logic [7:0]        hour4_q, min4_q, min5_q, sec4_q, sec5_q, sec6_q;

  logic [14:0] dy;
  logic [10:0] rem_days;
  logic        yr_ok;
  logic        leap_add;

  always_comb begin
    yr_ok = (year_q >= YearMin) && (year_q <= YearMax);
    dy    = year_q - YearMin;
    case (dy[1:0])
      2'd1:    rem_days = 11'd365;
      2'd2:    rem_days = 11'd730;
      2'd3:    rem_days = 11'd1096;
      default: rem_days = 11'd0;
    endcase
    leap_add = (year_q[1:0] == 2'd0) && late_mon_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cen_q   <= pair_val(text_high_i[63:48]);
      yy_q    <= pair_val(text_high_i[47:32]);
      mon_q   <= pair_val(text_high_i[31:16]);
      day1_q  <= pair_val(text_high_i[15:0]);
      hour1_q <= pair_val(text_low_i[47:32]);
      min1_q  <= pair_val(text_low_i[31:16]);
      sec1_q  <= pair_val(text_low_i[15:0]);

      year_q     <= {7'd0, cen_q} * 15'd100 + {7'd0, yy_q};
      mstart_q   <= month_start(mon_q);
      late_mon_q <= (mon_q >= 8'd3);
      day2_q     <= day1_q;
      hour2_q    <= hour1_q;
      min2_q     <= min1_q;
      sec2_q     <= sec1_q;

      // Only the low 13 bits of the year offset matter for a valid year.
      quad_days_q <= {11'd0, dy[12:2]} * QuadDays;
      side_days_q <= {1'b0, rem_days} + {3'd0, mstart_q} + {11'd0, leap_add};
      ok3_q       <= yr_ok;
      day3_q      <= day2_q;
      hour3_q     <= hour2_q;
      min3_q      <= min2_q;
      sec3_q      <= sec2_q;

      // A day of zero counts as minus one day, wrapping in 32 bits.
      days_q  <= {10'd0, quad_days_q} + {20'd0, side_days_q} + {24'd0, day3_q}
                 - 32'd1;
      ok4_q   <= ok3_q;
      hour4_q <= hour3_q;
      min4_q  <= min3_q;
      sec4_q  <= sec3_q;

      hrs_q  <= days_q * 32'd24 + {24'd0, hour4_q};
      ok5_q  <= ok4_q;
      min5_q <= min4_q;
      sec5_q <= sec4_q;

      mins_q <= hrs_q * 32'd60 + {24'd0, min5_q};
      ok6_q  <= ok5_q;
      sec6_q <= sec5_q;

      secs_q <= ok6_q ? (mins_q * 32'd60 + {24'd0, sec6_q}) : '0;
    end
  end

  assign epoch_o = secs_q;

endmodule

FILE: rtl/adep_merge.sv
// ----------------------------------------------------------------------------
// adep_merge
// Combines the two lane results, forms their difference and holds the result.
// ----------------------------------------------------------------------------
module adep_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [adep_pkg::EpochW-1:0] cur_i,
  input  logic [adep_pkg::EpochW-1:0] last_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output adep_pkg::out_item_t        out_item_o
);
  import adep_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // The pipeline may advance whenever the held item is absent or being taken.
  assign ready_o = !(valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q.cur_epoch        <= cur_i;
      item_q.last_epoch       <= last_i;
      item_q.epoch_difference <= cur_i - last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: rtl/ascii_datetime_to_epoch_diff.sv
// ----------------------------------------------------------------------------
// ascii_datetime_to_epoch_diff
// Converts a pair of CCYYMMDDhhmmss ASCII timestamps to seconds since 1970.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the output side is not
// stalled and returns each result through seven register stages in each of
// the two conversion lanes, which work on the current and the earlier
// timestamp side by side, and one output register that holds both epoch
// values and their difference. The whole pipeline advances together, so
// in_stall_o follows out_stall_i while a result is waiting.
// Year outside 1970 to 9000 gives an epoch of zero; all sums wrap in 32 bits.
module ascii_datetime_to_epoch_diff (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  adep_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output adep_pkg::out_item_t  out_item_o
);
  import adep_pkg::*;

  logic                  adv;
  logic [LaneStages-1:0] vld_q;
  logic [EpochW-1:0]     cur_epoch;
  logic [EpochW-1:0]     last_epoch;

  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LaneStages-2:0], in_valid_i};
    end
  end

  adep_lane u_lane_cur (
    .clk_i       (clk_i),
    .en_i        (adv),
    .text_high_i (in_item_i.cur_text_high),
    .text_low_i  (in_item_i.cur_text_low),
    .epoch_o     (cur_epoch)
  );

  adep_lane u_lane_last (
    .clk_i       (clk_i),
    .en_i        (adv),
    .text_high_i (in_item_i.last_text_high),
    .text_low_i  (in_item_i.last_text_low),
    .epoch_o     (last_epoch)
  );

  adep_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_q[LaneStages-1]),
    .cur_i       (cur_epoch),
    .last_i      (last_epoch),
    .ready_o     (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for ascii_datetime_to_epoch_diff. A short table of
// timestamp pairs covers the field extremes, out-of-range years, odd months,
// day zero, non-digit characters and 32-bit wrap-around. It is followed by
// random pairs with random idling on both sides and one long output hold-off.
// Every result is compared with a typed expectation or a predictor of the conversion.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import adep_pkg::*;

  localparam int unsigned RandomItems = 1950;

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t result;
  } stamp_vector_t;

  logic      clk_i        = 1'b0;
  logic      rst_ni       = 1'b0;
  logic      in_valid_i   = 1'b0;
  logic      out_stall_i  = 1'b0;
  in_item_t  in_item_i    = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Typed expectation that travels alongside the item being offered.
  bit        typed_known  = 1'b0;
  out_item_t typed_result = '0;

  out_item_t     expected_epochs[$];
  stamp_vector_t stamp_table[$];
  int unsigned   n_fail   = 0;
  int unsigned   in_count = 0;

  ascii_datetime_to_epoch_diff uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---- Conversion predictor -------------------------------------------------

  function automatic bit [7:0] digit_pair(bit [15:0] chars);
    bit [7:0] hi_d;
    bit [7:0] lo_d;
    hi_d = chars[15:8] - 8'd48;
    lo_d = chars[7:0] - 8'd48;
    return hi_d * 8'd10 + lo_d;
  endfunction

  function automatic bit [31:0] seconds_since_1970(bit [111:0] stamp);
    bit [31:0] year;
    bit [31:0] yrs;
    bit [31:0] rem;
    bit [31:0] days;
    bit [31:0] mdays;
    bit [7:0]  month;
    year  = 32'(digit_pair(stamp[111:96])) * 32'd100 + 32'(digit_pair(stamp[95:80]));
    month = digit_pair(stamp[79:64]);
    if (year < 32'd1970 || year > 32'd9000) begin
      return 32'd0;
    end
    yrs  = year - 32'd1970;
    rem  = yrs % 32'd4;
    days = (yrs / 32'd4) * 32'd1461;
    // The third year of each group after 1970 is the leap year.
    if (rem >= 32'd3) begin
      days += (rem - 32'd1) * 32'd365 + 32'd366;
    end else begin
      days += rem * 32'd365;
    end
    case (month)
      8'd2:    mdays = 32'd31;
      8'd3:    mdays = 32'd59;
      8'd4:    mdays = 32'd90;
      8'd5:    mdays = 32'd120;
      8'd6:    mdays = 32'd151;
      8'd7:    mdays = 32'd181;
      8'd8:    mdays = 32'd212;
      8'd9:    mdays = 32'd243;
      8'd10:   mdays = 32'd273;
      8'd11:   mdays = 32'd304;
      8'd12:   mdays = 32'd334;
      default: mdays = 32'd0;
    endcase
    // The leap day is added for any month from three up, even invalid ones.
    if (year % 32'd4 == 32'd0 && month >= 8'd3) begin
      mdays += 32'd1;
    end
    days += mdays + 32'(digit_pair(stamp[63:48])) - 32'd1;
    return ((days * 32'd24 + 32'(digit_pair(stamp[47:32]))) * 32'd60
            + 32'(digit_pair(stamp[31:16]))) * 32'd60 + 32'(digit_pair(stamp[15:0]));
  endfunction

  function automatic out_item_t convert_pair(in_item_t item);
    out_item_t res;
    res.cur_epoch        = seconds_since_1970({item.cur_text_high, item.cur_text_low});
    res.last_epoch       = seconds_since_1970({item.last_text_high, item.last_text_low});
    res.epoch_difference = res.cur_epoch - res.last_epoch;
    return res;
  endfunction

  // ---- Timestamp builders ---------------------------------------------------

  function automatic bit [111:0] text(string s);
    bit [111:0] t;
    t = '0;
    for (int i = 0; i < 14; i++) begin
      t = {t[103:0], s[i]};
    end
    return t;
  endfunction

  function automatic bit [15:0] two_digits(int unsigned v);
    return {8'(48 + v / 10), 8'(48 + v % 10)};
  endfunction

  function automatic bit [111:0] rand_stamp();
    int unsigned r;
    int unsigned year;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      // Digits in the usual field ranges, with years mostly near the lower limit of the rule.
      year = ($urandom_range(0, 4) == 0) ? $urandom_range(1970, 9000)
                                         : $urandom_range(1965, 2110);
      return {two_digits(year / 100), two_digits(year % 100),
              two_digits($urandom_range(1, 12)), two_digits($urandom_range(1, 31)),
              two_digits($urandom_range(0, 23)), two_digits($urandom_range(0, 59)),
              two_digits($urandom_range(0, 59))};
    end else if (r < 90) begin
      // Digits only, but any pair value, with the years near the limits often.
      case ($urandom_range(0, 5))
        0:       year = 1969;
        1:       year = 1970;
        2:       year = 9000;
        3:       year = 9001;
        default: year = $urandom_range(0, 9999);
      endcase
      return {two_digits(year / 100), two_digits(year % 100),
              two_digits($urandom_range(0, 99)), two_digits($urandom_range(0, 99)),
              two_digits($urandom_range(0, 99)), two_digits($urandom_range(0, 99)),
              two_digits($urandom_range(0, 99))};
    end
    return 112'({$urandom(), $urandom(), $urandom(), $urandom()});
  endfunction

  task automatic add_stamps(bit [111:0] cur, bit [111:0] last, bit known,
                            int c, int l, int d);
    stamp_vector_t v;
    v.item                    = in_item_t'({cur, last});
    v.known                   = known;
    v.result.cur_epoch        = c;
    v.result.last_epoch       = l;
    v.result.epoch_difference = d;
    stamp_table.push_back(v);
  endtask

  // ---- Input side -----------------------------------------------------------

  task automatic offer(in_item_t item, bit known, out_item_t result);
    int unsigned gap;
    int unsigned r;
    in_item_i    <= item;
    typed_known  <= known;
    typed_result <= result;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = $urandom_range(0, 99);
    if (in_count >= 300 && in_count < 480) begin
      gap = 0; // keep offering while the output side is held off
    end else if (r < 65) begin
      gap = 0;
    end else if (r < 95) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 25);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    in_item_t cur_item;
    bit       quiet;
    quiet = 1'b0;

    add_stamps(text("19700101000000"), text("19700101000000"), 1, 0, 0, 0);
    add_stamps(text("19700101000001"), text("19700101000000"), 1, 1, 0, 1);
    add_stamps(text("19700101000000"), text("19700101000001"), 1, 0, 1, -1);
    add_stamps('0, '0, 1, 0, 0, 0);
    add_stamps('1, '1, 1, 0, 0, 0);
    add_stamps(text("19691231235959"), text("19700101000000"), 1, 0, 0, 0);
    add_stamps(text("90010101000000"), text("19691231235959"), 1, 0, 0, 0);
    add_stamps(text("90001231235959"), text("19700101000000"), 0, 0, 0, 0);
    add_stamps(text("89991231235959"), text("90000101000000"), 0, 0, 0, 0);
    add_stamps(text("20991231235959"), text("19700101000000"), 0, 0, 0, 0);
    add_stamps(text("20000229120000"), text("20000301000000"), 0, 0, 0, 0);
    add_stamps(text("19720301000000"), text("19720228235959"), 0, 0, 0, 0);
    add_stamps(text("19730101000000"), text("19740101000000"), 0, 0, 0, 0);
    add_stamps(text("21000301000000"), text("20991231235959"), 0, 0, 0, 0);
    add_stamps(text("20240001000000"), text("20241301000000"), 0, 0, 0, 0);
    add_stamps(text("20249901000000"), text("20240100000000"), 0, 0, 0, 0);
    add_stamps(text("20240615999999"), text("20230615000000"), 0, 0, 0, 0);
    add_stamps(text("1970AB01:0:0zz"), text("2024??01 0 0  "), 0, 0, 0, 0);
    add_stamps(text("20380119031407"), text("20380119031408"), 0, 0, 0, 0);
    add_stamps(text("20380119031408"), text("19700101000000"), 0, 0, 0, 0);
    add_stamps({64'hA5A5_A5A5_A5A5_A5A5, 48'h5A5A_5A5A_5A5A},
               {64'h5A5A_5A5A_5A5A_5A5A, 48'hA5A5_A5A5_A5A5}, 0, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stamp_table[i]) begin
      offer(stamp_table[i].item, stamp_table[i].known, stamp_table[i].result);
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      cur_item = in_item_t'({rand_stamp(), rand_stamp()});
      if (quiet) begin
        in_item_i    <= cur_item;
        typed_known  <= 1'b0;
        in_valid_i   <= 1'b1;
        do @(posedge clk_i); while (in_stall_o);
      end else begin
        offer(cur_item, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // Step past the last accepting edge so that its item is already queued.
    do @(posedge clk_i); while (expected_epochs.size() != 0);
    repeat (30) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---- Output side stalls ---------------------------------------------------

  initial begin : output_stall
    int unsigned hold;
    int unsigned cycles;
    int unsigned r;
    bit          quiet;
    bit          held_off;
    hold     = 0;
    cycles   = 0;
    quiet    = 1'b0;
    held_off = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles % 128 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (!held_off && in_count >= 320) begin
        // One long hold-off so that the pipeline fills and stalls its input.
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (100) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          out_stall_i <= 1'b1;
          hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 29);
        end
      end
    end
  end

  // ---- Checking -------------------------------------------------------------

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_epochs.push_back(typed_known ? typed_result : convert_pair(in_item_i));
      in_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_epochs.size() == 0) begin
        $display("%0t: unexpected result, expected none got %0d %0d %0d", $time,
                 out_item_o.cur_epoch, out_item_o.last_epoch,
                 out_item_o.epoch_difference);
        n_fail++;
      end else begin
        want = expected_epochs.pop_front();
        compare_field("cur_epoch", want.cur_epoch, out_item_o.cur_epoch);
        compare_field("last_epoch", want.last_epoch, out_item_o.last_epoch);
        compare_field("epoch_difference", want.epoch_difference,
                      out_item_o.epoch_difference);
      end
    end
  end

endmodule
